// File: rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared constants and register index codes for the clamped PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int TIME_W    = 32;
  localparam int PERIOD_W  = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_TARGET,
    REG_PERIOD,
    REG_DMIN,
    REG_DMAX,
    REG_AUTO
  } reg_idx_t;

endpackage

// File: rtl/pidc_calc.sv
// ----------------------------------------------------------------------------
// pidc_calc
// Single-pass PID datapath: sample period check, error, integral update and
// clamped drive with derivative on measurement.
// ----------------------------------------------------------------------------
module pidc_calc
  import pidc_pkg::*;
#(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic signed [VALUE_WIDTH-1:0] sample,
  input  logic        [TIME_W-1:0]      now_ms,
  input  logic signed [VALUE_WIDTH-1:0] prev_sample,
  input  logic signed [VALUE_WIDTH-1:0] integral,
  input  logic        [TIME_W-1:0]      last_time,
  input  logic signed [VALUE_WIDTH-1:0] kp,
  input  logic signed [VALUE_WIDTH-1:0] ki,
  input  logic signed [VALUE_WIDTH-1:0] kd,
  input  logic signed [VALUE_WIDTH-1:0] target,
  input  logic signed [VALUE_WIDTH-1:0] dmin,
  input  logic signed [VALUE_WIDTH-1:0] dmax,
  input  logic        [PERIOD_W-1:0]    period,
  input  logic                          auto_on,
  output logic                          compute,
  output logic signed [VALUE_WIDTH-1:0] integral_nxt,
  output logic signed [VALUE_WIDTH-1:0] drive
);

  localparam int V  = VALUE_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int PW = 2 * VALUE_WIDTH;

  localparam logic signed [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
  localparam logic signed [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};
  localparam logic signed [PW-1:0] RND = PW'({F{1'b1}});

  // saturating difference
  function automatic logic signed [V-1:0] sat_sub(input logic signed [V-1:0] a,
                                                  input logic signed [V-1:0] b);
    logic signed [V:0] d;
    d = (V+1)'(a) - (V+1)'(b);
    if (d[V] != d[V-1]) return d[V] ? VMIN : VMAX;
    return d[V-1:0];
  endfunction

  // product, shift toward zero, saturate
  function automatic logic signed [V-1:0] qmul(input logic signed [V-1:0] a,
                                               input logic signed [V-1:0] b);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
    p = PW'(a) * PW'(b);
    if (p[PW-1]) p = p + RND;
    q = p >>> F;
    if (q[PW-1:V-1] != {(PW-V+1){q[PW-1]}}) return q[PW-1] ? VMIN : VMAX;
    return q[V-1:0];
  endfunction

  function automatic logic signed [V-1:0] lim(input logic signed [V+1:0] x,
                                              input logic signed [V-1:0] lo,
                                              input logic signed [V-1:0] hi);
    if (x > (V+2)'(hi)) return hi;
    if (x < (V+2)'(lo)) return lo;
    return x[V-1:0];
  endfunction

  logic [TIME_W-1:0]      elapsed;
  logic signed [V-1:0]    err;
  logic signed [V-1:0]    dif;
  logic signed [V-1:0]    p_term;
  logic signed [V-1:0]    i_term;
  logic signed [V-1:0]    d_term;
  logic signed [V+1:0]    i_sum;
  logic signed [V+1:0]    d_sum;

  always_comb begin
    elapsed      = now_ms - last_time;
    compute      = auto_on && (elapsed >= TIME_W'(period));
    err          = sat_sub(sample, target);
    dif          = sat_sub(sample, prev_sample);
    p_term       = qmul(kp, err);
    i_term       = qmul(ki, err);
    d_term       = qmul(kd, dif);
    i_sum        = (V+2)'(integral) + (V+2)'(i_term);
    integral_nxt = lim(i_sum, dmin, dmax);
    d_sum        = (V+2)'(p_term) + (V+2)'(integral_nxt) - (V+2)'(d_term);
    drive        = lim(d_sum, dmin, dmax);
  end

endmodule

// File: rtl/pid_controller_clamped_top.sv
// Accepted beats go via the input register, then the result register, to out_*.
// Throughput: one input beat per cycle while out_tready stays high; the
// single-pass datapath between the input and result registers sets that rate.
// A sample that does not compute (manual mode or period not elapsed) gives no beat.
// Reset (rst_n low, synchronous) clears valids and PID state; loads cfg defaults.
// ----------------------------------------------------------------------------
// pid_controller_clamped_top
// Clamped PID controller, derivative on measurement, fixed point, streaming.
// ----------------------------------------------------------------------------
module pid_controller_clamped_top
  import pidc_pkg::*;
#(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: measurement [VALUE_WIDTH-1:0], now_ms [VALUE_WIDTH+31:VALUE_WIDTH]
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VALUE_WIDTH+32+7)/8)*8-1:0]  in_tdata,
  // out_tdata: drive_value [VALUE_WIDTH-1:0]
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]     out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic signed [VALUE_WIDTH-1:0]         cfg_wdata
);

  localparam int V     = VALUE_WIDTH;
  localparam int OUT_W = ((VALUE_WIDTH+7)/8)*8;

  localparam logic signed [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
  localparam logic signed [V-1:0] DMAX_RESET =
    (V > 25) ? V'(32'd16777215) : VMAX;

  function automatic logic signed [V-1:0] clamp_v(input logic signed [V-1:0] x,
                                                  input logic signed [V-1:0] lo,
                                                  input logic signed [V-1:0] hi);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // configuration
  logic signed [V-1:0]  kp_r, ki_r, kd_r, target_r, dmin_r, dmax_r;
  logic [PERIOD_W-1:0]  period_r;
  logic                 auto_r;

  // controller state
  logic signed [V-1:0]  latest_r, prev_r, integral_r, last_drive_r;
  logic [TIME_W-1:0]    last_time_r;

  // input stage and result register
  logic                 s1_valid_r;
  logic signed [V-1:0]  s1_meas_r;
  logic [TIME_W-1:0]    s1_now_r;
  logic                 out_valid_r;
  logic [V-1:0]         out_data_r;

  logic                 s1_adv;
  logic                 in_fire;
  logic                 s1_valid_nxt;
  logic                 compute;
  logic signed [V-1:0]  integral_nxt;
  logic signed [V-1:0]  drive;

  pidc_calc #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_calc (
    .sample       (s1_meas_r),
    .now_ms       (s1_now_r),
    .prev_sample  (prev_r),
    .integral     (integral_r),
    .last_time    (last_time_r),
    .kp           (kp_r),
    .ki           (ki_r),
    .kd           (kd_r),
    .target       (target_r),
    .dmin         (dmin_r),
    .dmax         (dmax_r),
    .period       (period_r),
    .auto_on      (auto_r),
    .compute      (compute),
    .integral_nxt (integral_nxt),
    .drive        (drive)
  );

  // stage 1 moves on unless it would overwrite a result still waiting
  assign s1_adv       = s1_valid_r && !(out_valid_r && !out_tready);
  assign in_tready    = !s1_valid_r || s1_adv;
  assign in_fire      = in_tvalid && in_tready;
  assign s1_valid_nxt = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_meas_r <= in_tdata[V-1:0];
      s1_now_r  <= in_tdata[V+TIME_W-1:V];
    end
    if (s1_adv && compute) begin
      out_data_r <= drive;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r         <= '0;
      ki_r         <= '0;
      kd_r         <= '0;
      target_r     <= '0;
      period_r     <= PERIOD_RESET;
      dmin_r       <= '0;
      dmax_r       <= DMAX_RESET;
      auto_r       <= 1'b0;
      latest_r     <= '0;
      prev_r       <= '0;
      integral_r   <= '0;
      last_drive_r <= '0;
      last_time_r  <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;

      if (s1_adv && compute) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_wr_en) begin
        unique case (reg_idx_t'(cfg_index))
          REG_KP:     kp_r     <= cfg_wdata;
          REG_KI:     ki_r     <= cfg_wdata;
          REG_KD:     kd_r     <= cfg_wdata;
          REG_TARGET: target_r <= cfg_wdata;
          REG_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
          REG_DMIN: begin
            // crossed limits are dropped
            if (cfg_wdata <= dmax_r) begin
              dmin_r       <= cfg_wdata;
              last_drive_r <= clamp_v(last_drive_r, cfg_wdata, dmax_r);
              integral_r   <= clamp_v(integral_r, cfg_wdata, dmax_r);
            end
          end
          REG_DMAX: begin
            if (dmin_r <= cfg_wdata) begin
              dmax_r       <= cfg_wdata;
              last_drive_r <= clamp_v(last_drive_r, dmin_r, cfg_wdata);
              integral_r   <= clamp_v(integral_r, dmin_r, cfg_wdata);
            end
          end
          REG_AUTO: begin
            // bumpless restart on manual -> auto
            if (cfg_wdata[0] && !auto_r) begin
              prev_r     <= latest_r;
              integral_r <= clamp_v(last_drive_r, dmin_r, dmax_r);
            end
            auto_r <= cfg_wdata[0];
          end
          default: ;
        endcase
      end

      if (s1_adv) begin
        latest_r <= s1_meas_r;
        if (compute) begin
          integral_r   <= integral_nxt;
          last_drive_r <= drive;
          prev_r       <= s1_meas_r;
          last_time_r  <= s1_now_r;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline valid not cleared by reset");

  a_limits_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    dmin_r <= dmax_r)
    else $error("drive limits crossed");

  a_integral_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (integral_r >= dmin_r) && (integral_r <= dmax_r))
    else $error("integral outside drive limits");

  a_result_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && compute) |=> out_tvalid && (out_tdata[V-1:0] == $past(drive)))
    else $error("computed drive not presented");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled without a blocked result");
`endif

endmodule

// File: tb/pid_controller_clamped_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_top_test
// Drives timestamped samples into the clamped PID controller. A scoreboard
// keeps its own copy of the gains, limits and controller state, predicts each
// drive beat and checks it against the output stream under random backpressure.
// ----------------------------------------------------------------------------
module pid_controller_clamped_top_test
  import pidc_pkg::*;
();

  localparam int CYCLE_LIMIT = 300000;
  localparam int ITEMS_PER_PHASE = 50;

  // ---------------------------------------------------------------------------
  class pid_scoreboard;
    longint kp, ki, kd, target, dmin, dmax;
    logic [15:0] period;
    bit auto_on;
    longint latest, prev, integ, last_drv;
    logic [31:0] last_time;
    logic [31:0] drive_q[$];
    int fails;

    function new();
      kp = 0; ki = 0; kd = 0; target = 0;
      period = PERIOD_RESET;
      dmin = 0; dmax = 64'sd16777215;
      auto_on = 1'b0;
      latest = 0; prev = 0; integ = 0; last_drv = 0;
      last_time = '0;
      fails = 0;
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint clamp_lim(longint v);
      if (v > dmax) return dmax;
      if (v < dmin) return dmin;
      return v;
    endfunction

    // Q16.16 multiply: exact product, truncate toward zero, saturate
    function longint fx_mul(longint a, longint b);
      bit neg;
      logic [63:0] ua, ub, p, top;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      p = (ua * ub) >> 16;
      top = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (p > top) p = top;
      return neg ? -longint'(p) : longint'(p);
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] val);
      longint v, mn, mx;
      v = $signed(val);
      unique case (idx) inside
        REG_KP:     kp = v;
        REG_KI:     ki = v;
        REG_KD:     kd = v;
        REG_TARGET: target = v;
        REG_PERIOD: period = val[15:0];
        REG_DMIN, REG_DMAX: begin
          mn = (idx == REG_DMIN) ? v : dmin;
          mx = (idx == REG_DMAX) ? v : dmax;
          // inverted limits are dropped
          if (mn <= mx) begin
            dmin = mn;
            dmax = mx;
            last_drv = clamp_lim(last_drv);
            integ = clamp_lim(integ);
          end
        end
        REG_AUTO: begin
          // bumpless restart on manual -> auto
          if (val[0] && !auto_on) begin
            prev = latest;
            integ = clamp_lim(last_drv);
          end
          auto_on = val[0];
        end
        default: ;
      endcase
    endfunction

    function void note_sample(logic [31:0] meas, logic [31:0] now);
      longint err, dif, drv;
      logic [31:0] elapsed;
      latest = $signed(meas);
      if (!auto_on) return;
      elapsed = now - last_time;
      if (elapsed < {16'd0, period}) return;
      err = sat32(latest - target);
      integ = clamp_lim(integ + fx_mul(ki, err));
      dif = sat32(latest - prev);
      drv = clamp_lim(fx_mul(kp, err) + integ - fx_mul(kd, dif));
      last_drv = drv;
      prev = latest;
      last_time = now;
      drive_q.push_back(drv[31:0]);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      fails++;
    endtask

    task check_drive(logic [31:0] got);
      logic [31:0] want;
      if (drive_q.size() == 0) begin
        report($sformatf("drive beat %h with none expected", got));
        return;
      end
      want = drive_q.pop_front();
      if (got !== want) report($sformatf("drive_value got %h, want %h", got, want));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  // in_tdata: measurement [31:0], now_ms [63:32]
  logic [63:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  // out_tdata: drive_value [31:0]
  logic [31:0]          out_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  pid_scoreboard sb = new();

  pid_controller_clamped_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_sample(in_tdata[31:0], in_tdata[63:32]);
      if (out_tvalid && out_tready) sb.check_drive(out_tdata);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // mostly small values within +/-span, some full-range, some corner values
  function automatic logic [31:0] rand_val(int unsigned span);
    case ($urandom_range(9))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic send_sample(input logic [31:0] meas, input logic [31:0] now);
    cfg_wr_en <= 1'b0;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {now, meas};
    do @(posedge clk); while (!in_tready);
  endtask

  // wait for all drive beats, then let the input and result registers empty
  task automatic drain();
    in_tvalid <= 1'b0;
    cfg_wr_en <= 1'b0;
    do @(posedge clk); while (sb.drive_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] cursor, now, meas, lo, hi, tmp, tgt;
    int unsigned per;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // manual mode after reset: samples stored, no beats
    send_sample(32'h7FFF_FFFF, 32'h0000_0000);
    send_sample(32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(32'h0000_0000, 32'd200);
    drain();

    cfg_write(REG_KP, 32'h0001_0000);
    cfg_write(REG_KI, 32'h0000_8000);
    cfg_write(REG_KD, 32'h0000_4000);
    cfg_write(REG_TARGET, 32'h0005_0000);
    cfg_write(REG_DMIN, -(32'd100 << 16));
    cfg_write(REG_DMAX, 32'd100 << 16);
    cfg_write(REG_PERIOD, 32'hABCD_000A);  // upper bits ignored
    cfg_write(REG_AUTO, 32'h0000_0001);

    send_sample(32'h0007_0000, 32'd1000);
    send_sample(32'h0008_0000, 32'd1005);  // period not yet up
    send_sample(32'h0006_0000, 32'd1010);
    send_sample(32'h7FFF_FFFF, 32'd1020);
    send_sample(32'h8000_0000, 32'd1030);
    send_sample(32'h0001_0000, 32'hFFFF_FFF8);
    send_sample(32'h0002_0000, 32'h0000_0002);  // timestamp wrap
    drain();

    cfg_write(REG_AUTO, 32'hFFFF_FFFE);
    send_sample(32'h0003_0000, 32'd20);
    drain();
    cfg_write(REG_AUTO, 32'h0000_0003);
    cfg_write(REG_AUTO, 32'h0000_0001);      // already on: no restart
    send_sample(32'h0004_0000, 32'd40);
    drain();

    cfg_write(REG_DMIN, 32'd200 << 16);      // above max: dropped
    cfg_write(REG_DMAX, 32'h0001_0000);
    cfg_write(REG_DMIN, 32'h0001_0000);
    send_sample(32'hFFF0_0000, 32'd60);
    drain();

    cfg_write(REG_DMIN, 32'h8000_0000);
    cfg_write(REG_DMAX, 32'h7FFF_FFFF);
    cfg_write(REG_PERIOD, 32'hFFFF_0000);
    cfg_write(REG_KP, 32'h7FFF_FFFF);
    cfg_write(REG_KI, 32'h8000_0000);
    cfg_write(REG_KD, 32'h8000_0000);
    cfg_write(REG_TARGET, 32'h0000_0000);
    send_sample(32'h7FFF_FFFF, 32'd60);      // zero period: same stamp computes
    send_sample(32'h8000_0000, 32'd60);
    send_sample(32'hFFFF_FFFF, 32'd60);
    send_sample(32'h0000_0001, 32'd60);

    cursor = 32'd60;
    for (int p = 0; p < 8; p++) begin
      drain();
      case (p % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 60; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase

      tgt = rand_val(32'h0100_0000);
      cfg_write(REG_KP, rand_val(32'h0004_0000));
      cfg_write(REG_KI, rand_val(32'h0001_0000));
      cfg_write(REG_KD, rand_val(32'h0001_0000));
      cfg_write(REG_TARGET, tgt);

      per = (p == 0) ? 0 : (p == 7) ? 65535 : $urandom_range(1, 300);
      tmp = $urandom();
      tmp[15:0] = per[15:0];
      cfg_write(REG_PERIOD, tmp);

      case ((p == 0 || p == 7) ? 0 : $urandom_range(2))
        0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
        1: begin
          lo = rand_val(32'h0100_0000);
          hi = rand_val(32'h0100_0000);
          if ($signed(lo) > $signed(hi)) begin
            tmp = lo; lo = hi; hi = tmp;
          end
        end
        default: begin lo = -(32'd50 << 16); hi = 32'd50 << 16; end
      endcase
      cfg_write(REG_DMIN, 32'h8000_0000);
      cfg_write(REG_DMAX, hi);
      cfg_write(REG_DMIN, lo);
      if ($urandom_range(3) == 0) cfg_write(REG_DMIN, hi + 32'h0001_0000);

      if ($urandom_range(1) == 1) begin
        tmp = $urandom();
        tmp[0] = 1'b0;
        cfg_write(REG_AUTO, tmp);
        repeat (2) send_sample($urandom(), $urandom());
        drain();
      end
      tmp = $urandom();
      tmp[0] = 1'b1;
      cfg_write(REG_AUTO, tmp);

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        case ($urandom_range(9))
          0:       now = $urandom();
          1:       now = cursor;
          default: now = cursor + $urandom_range(0, 2 * per + 2);
        endcase
        cursor = now;
        meas = ($urandom_range(4) != 0) ? tgt + rand_val(32'h0004_0000) : $urandom();
        send_sample(meas, now);
      end
    end

    in_tvalid <= 1'b0;
    while (sb.drive_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.drive_q.size() != 0)
      sb.report($sformatf("%0d drive beats never arrived", sb.drive_q.size()));

    if (sb.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
